[rtl/core/grt_pkg.sv]
// Shared types and constants for the gradient ramp table.
// No dependencies.
package grt_pkg;

  localparam int MARKER_LIMIT_DEF = 8;
  localparam int ENT_W = 80;

  typedef enum logic [2:0] {
    CMD_ADD_COLOR = 3'd0,
    CMD_ADD_ALPHA = 3'd1,
    CMD_REM_COLOR = 3'd2,
    CMD_REM_ALPHA = 3'd3,
    CMD_SAMPLE    = 3'd4
  } cmd_t;

  typedef struct packed {
    logic        go;
    logic [15:0] num;
    logic [15:0] den;
  } div_req_t;

endpackage

[rtl/core/grt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/grt_div.sv]
// Iterative restoring divider: quot = (num << 16) / den, num < den, one bit per cycle.
// Depends on grt_pkg.
module grt_div import grt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic        busy,
  output logic [15:0] quot
);

  logic [16:0] rem;
  logic [15:0] den;
  logic [4:0]  cnt;
  logic [16:0] r2;
  logic        ge;

  assign r2 = {rem[15:0], 1'b0};
  assign ge = r2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        rem  <= {1'b0, req.num};
        den  <= req.den;
        cnt  <= 5'd16;
      end else if (busy) begin
        rem  <= ge ? r2 - {1'b0, den} : r2;
        quot <= {quot[14:0], ge};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/gradient_ramp_table.sv]
// Top level: sequencer over two marker RAMs, shared multiplier and divider.
// Depends on grt_pkg, grt_ram, grt_div.
//
// One command at a time: accepted when start is high and busy low; the result
// shows for one cycle with done, and the receiver cannot stall it. Adds shift
// markers up, removes move markers down, and a sample scans the markers of
// each table, runs the bit-serial divider for each interpolating table, then
// blends the channels and scales the color ones on the shared multiplier; one
// RAM read port per table sets the scan pace. No clearing pass after reset.
module gradient_ramp_table import grt_pkg::*; #(
  parameter int MARKER_LIMIT = MARKER_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [15:0] position,
  input  logic [15:0] red_in,
  input  logic [15:0] green_in,
  input  logic [15:0] blue_in,
  input  logic [15:0] intensity_in,
  input  logic [15:0] alpha_in,
  input  logic [7:0]  index,
  output logic        done,
  output logic        ok,
  output logic [23:0] red_out,
  output logic [23:0] green_out,
  output logic [23:0] blue_out,
  output logic [15:0] alpha_out,
  output logic [3:0]  color_markers,
  output logic [3:0]  alpha_markers
);

  localparam int AW = $clog2(MARKER_LIMIT);
  localparam int CW = $clog2(MARKER_LIMIT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CHK, S_REM_RD, S_REM_WR, S_LK_LAST, S_LK_LAST_CHK,
    S_LK_RD, S_LK_CHK, S_DIV, S_BL_MUL, S_BL_ACC, S_SC_MUL, S_SC_ACC, S_FIN
  } state_t;

  state_t             state;
  logic               tsel;
  logic [CW-1:0]      i;
  logic [CW-1:0]      ccount;
  logic [CW-1:0]      acount;
  logic [15:0]        x_r;
  logic [ENT_W-1:0]   new_ent;
  logic [ENT_W-1:0]   lo_ent;
  logic [ENT_W-1:0]   hi_ent;
  logic [ENT_W-1:0]   prev_ent;
  logic [15:0]        f;
  logic [1:0]         ch;
  logic [15:0]        vals [4];
  logic signed [35:0] prod;

  logic [CW-1:0]      n;
  logic [CW:0]        i_inc;
  logic [ENT_W-1:0]   c_rd;
  logic [31:0]        a_rd;
  logic [ENT_W-1:0]   rd_ent;
  logic [15:0]        rd_pos;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [ENT_W-1:0]   wdata;
  logic               we;
  logic signed [17:0] ma;
  logic signed [17:0] mb;
  logic [15:0]        lo_ch;
  logic [15:0]        hi_ch;
  logic [15:0]        bl_res;
  logic signed [19:0] bl_sum;
  div_req_t           dreq;
  logic               div_done;
  logic               div_busy;
  logic [15:0]        quot;

  assign busy = state != S_IDLE;
  assign color_markers = 4'(ccount);
  assign alpha_markers = 4'(acount);
  assign n = tsel ? acount : ccount;
  assign i_inc = {1'b0, i} + (CW+1)'(1);
  assign rd_ent = tsel ? {a_rd[31:16], 48'd0, a_rd[15:0]} : c_rd;
  assign rd_pos = rd_ent[79:64];

  always_comb begin
    unique case (state)
      S_INS_RD:  raddr = AW'(i - CW'(1));
      S_REM_RD:  raddr = i_inc[AW-1:0];
      S_LK_LAST: raddr = AW'(n - CW'(1));
      default:   raddr = i[AW-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = i[AW-1:0];
    wdata = new_ent;
    unique case (state)
      S_INS_RD: we = i == '0;
      S_INS_CHK: begin
        we = 1'b1;
        if (rd_pos >= x_r) wdata = rd_ent;
      end
      S_REM_WR: begin
        we    = 1'b1;
        wdata = rd_ent;
      end
      default: we = 1'b0;
    endcase
  end

  grt_ram #(.WIDTH(ENT_W), .DEPTH(MARKER_LIMIT)) u_color_ram (
    .clk(clk), .we(we && !tsel), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(c_rd)
  );

  grt_ram #(.WIDTH(32), .DEPTH(MARKER_LIMIT)) u_alpha_ram (
    .clk(clk), .we(we && tsel), .waddr(waddr), .wdata({wdata[79:64], wdata[15:0]}),
    .raddr(raddr), .rdata(a_rd)
  );

  always_comb begin
    dreq.go  = state == S_LK_CHK && rd_pos >= x_r && i != '0 && rd_pos != x_r;
    dreq.num = x_r - prev_ent[79:64];
    dreq.den = rd_pos - prev_ent[79:64];
  end

  grt_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .done(div_done), .busy(div_busy), .quot(quot)
  );

  always_comb begin
    unique case (ch)
      2'd0: begin lo_ch = lo_ent[63:48]; hi_ch = hi_ent[63:48]; end
      2'd1: begin lo_ch = lo_ent[47:32]; hi_ch = hi_ent[47:32]; end
      2'd2: begin lo_ch = lo_ent[31:16]; hi_ch = hi_ent[31:16]; end
      default: begin lo_ch = lo_ent[15:0]; hi_ch = hi_ent[15:0]; end
    endcase
    if (state == S_SC_MUL) begin
      ma = signed'({2'b00, vals[ch]});
      mb = signed'({2'b00, vals[3]});
    end else begin
      ma = signed'({2'b00, hi_ch}) - signed'({2'b00, lo_ch});
      mb = signed'({2'b00, f});
    end
    bl_sum = signed'({4'd0, lo_ch}) + prod[35:16];
    bl_res = bl_sum[15:0];
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      ccount <= '0;
      acount <= '0;
      tsel   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          x_r       <= position;
          ok        <= 1'b0;
          red_out   <= '0;
          green_out <= '0;
          blue_out  <= '0;
          alpha_out <= '0;
          state     <= S_FIN;
          unique case (cmd)
            CMD_ADD_COLOR: begin
              tsel    <= 1'b0;
              i       <= ccount;
              new_ent <= {position, red_in, green_in, blue_in, intensity_in};
              if (ccount < CW'(MARKER_LIMIT)) state <= S_INS_RD;
            end
            CMD_ADD_ALPHA: begin
              tsel    <= 1'b1;
              i       <= acount;
              new_ent <= {position, 48'd0, alpha_in};
              if (acount < CW'(MARKER_LIMIT)) state <= S_INS_RD;
            end
            CMD_REM_COLOR: begin
              tsel <= 1'b0;
              i    <= CW'(index);
              if (32'(index) < 32'(ccount)) state <= S_REM_RD;
            end
            CMD_REM_ALPHA: begin
              tsel <= 1'b1;
              i    <= CW'(index);
              if (32'(index) < 32'(acount)) state <= S_REM_RD;
            end
            CMD_SAMPLE: begin
              ok <= 1'b1;
              if (ccount != '0) begin
                tsel  <= 1'b0;
                state <= S_LK_LAST;
              end else begin
                red_out   <= 24'd65536;
                green_out <= 24'd65536;
                blue_out  <= 24'd65536;
                if (acount == '0) begin
                  alpha_out <= 16'hFFFF;
                end else begin
                  tsel  <= 1'b1;
                  state <= S_LK_LAST;
                end
              end
            end
            default: state <= S_FIN;
          endcase
        end
        S_INS_RD: if (i == '0) begin
          ok <= 1'b1;
          if (tsel) acount <= acount + CW'(1);
          else ccount <= ccount + CW'(1);
          state <= S_FIN;
        end else begin
          state <= S_INS_CHK;
        end
        S_INS_CHK: if (rd_pos >= x_r) begin
          i     <= i - CW'(1);
          state <= S_INS_RD;
        end else begin
          ok <= 1'b1;
          if (tsel) acount <= acount + CW'(1);
          else ccount <= ccount + CW'(1);
          state <= S_FIN;
        end
        S_REM_RD: if (i_inc >= {1'b0, n}) begin
          ok <= 1'b1;
          if (tsel) acount <= acount - CW'(1);
          else ccount <= ccount - CW'(1);
          state <= S_FIN;
        end else begin
          state <= S_REM_WR;
        end
        S_REM_WR: begin
          i     <= i_inc[CW-1:0];
          state <= S_REM_RD;
        end
        S_LK_LAST: state <= S_LK_LAST_CHK;
        S_LK_LAST_CHK: begin
          if (rd_pos <= x_r) begin
            lo_ent <= rd_ent;
            hi_ent <= rd_ent;
            f      <= '0;
            ch     <= tsel ? 2'd3 : 2'd0;
            state  <= S_BL_MUL;
          end else begin
            i     <= '0;
            state <= S_LK_RD;
          end
        end
        S_LK_RD: state <= S_LK_CHK;
        S_LK_CHK: begin
          if (rd_pos >= x_r) begin
            ch <= tsel ? 2'd3 : 2'd0;
            if (i == '0 || rd_pos == x_r) begin
              lo_ent <= rd_ent;
              hi_ent <= rd_ent;
              f      <= '0;
              state  <= S_BL_MUL;
            end else begin
              lo_ent <= prev_ent;
              hi_ent <= rd_ent;
              state  <= S_DIV;
            end
          end else begin
            prev_ent <= rd_ent;
            i        <= i + CW'(1);
            state    <= S_LK_RD;
          end
        end
        S_DIV: if (div_done) begin
          f     <= quot;
          state <= S_BL_MUL;
        end
        S_BL_MUL: state <= S_BL_ACC;
        S_BL_ACC: begin
          vals[ch] <= bl_res;
          if (ch != 2'd3) begin
            ch    <= ch + 2'd1;
            state <= S_BL_MUL;
          end else if (tsel) begin
            alpha_out <= bl_res;
            state     <= S_FIN;
          end else begin
            ch    <= 2'd0;
            state <= S_SC_MUL;
          end
        end
        S_SC_MUL: state <= S_SC_ACC;
        S_SC_ACC: begin
          unique case (ch)
            2'd0: red_out <= prod[31:8];
            2'd1: green_out <= prod[31:8];
            default: blue_out <= prod[31:8];
          endcase
          if (ch != 2'd2) begin
            ch    <= ch + 2'd1;
            state <= S_SC_MUL;
          end else if (acount == '0) begin
            alpha_out <= 16'hFFFF;
            state     <= S_FIN;
          end else begin
            tsel  <= 1'b1;
            state <= S_LK_LAST;
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    ccount <= CW'(MARKER_LIMIT) && acount <= CW'(MARKER_LIMIT))
    else $error("marker count beyond limit");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !div_busy)
    else $error("divider running while idle");

endmodule
